FILE: hw/rtl/ps2md_pkg.sv
package ps2md_pkg;

    // Header byte bits
    localparam logic [7:0] HDR_SYNC_BIT = 8'h08;
    localparam logic [7:0] HDR_OVERFLOW = 8'hc0;
    localparam logic [7:0] HDR_LEFT     = 8'h01;
    localparam logic [7:0] HDR_RIGHT    = 8'h02;
    localparam logic [7:0] HDR_MIDDLE   = 8'h04;

    // Button mask bits
    localparam logic [2:0] BTN_LEFT   = 3'b001;
    localparam logic [2:0] BTN_RIGHT  = 3'b010;
    localparam logic [2:0] BTN_MIDDLE = 3'b100;

    // Register map
    localparam int unsigned  ADDR_W     = 1;
    localparam logic [ADDR_W-1:0] REG_ENABLE = 1'b0;

    // Byte position within a packet
    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2
    } byte_pos_t;

    // One decoded packet
    typedef struct packed {
        logic [2:0]        button_mask;
        logic signed [8:0] delta_y;
        logic signed [7:0] delta_x;
    } result_t;

    // Header buttons to button mask
    function automatic logic [2:0] map_buttons(input logic [7:0] hdr);
        logic [2:0] b;
        b = '0;
        if ((hdr & HDR_LEFT) != 8'h00)
            b = b | BTN_LEFT;
        if ((hdr & HDR_MIDDLE) != 8'h00)
            b = b | BTN_MIDDLE;
        if ((hdr & HDR_RIGHT) != 8'h00)
            b = b | BTN_RIGHT;
        return b;
    endfunction

endpackage

FILE: hw/rtl/ps2_mouse_packet_decoder_top.sv
// Channel   Dir  Transfer when              Payload
// s_axis    in   s_tvalid & s_tready        tdata: data_byte; tuser: output_full, from_aux
// m_axis    out  m_tvalid & m_tready        tdata: delta_x, delta_y, button_mask
// apb       in   psel & penable & pwrite    enable at address 0
//
// One byte is taken every cycle while s_tready is high; a finished packet goes to the result
// register, or to the skid entry while that register holds a stalled packet. These two let
// input flow while the sink stalls; s_tready drops only once both are full. Reset clears
// enable, byte position, the last reported buttons and both output entries.
module ps2_mouse_packet_decoder_top
    import ps2md_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic [1:0]        s_tuser,   // [0] output_full, [1] from_aux

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // [7:0] delta_x, [16:8] delta_y,
                                         // [19:17] button_mask, [23:20] zero

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic       enable_reg;
    byte_pos_t  pos_reg, pos_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] x_reg, x_next;
    logic [2:0] prev_btn_reg, prev_btn_next;

    logic       out_valid_reg;
    result_t    out_data_reg;
    logic       skid_valid_reg;
    result_t    skid_data_reg;

    logic       in_xfer;
    logic       out_xfer;
    logic       cfg_write;
    logic       consume;
    logic       res_valid;
    result_t    res_data;
    logic [2:0] buttons;
    logic [8:0] y_ext;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid && m_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign consume   = in_xfer && s_tuser[0] && s_tuser[1];

    // APB read side
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (paddr == REG_ENABLE)
            prdata = {31'd0, enable_reg};
    end

    // Packet assembly and result decision
    assign buttons = map_buttons(header_reg);
    assign y_ext   = {s_tdata[7], s_tdata};

    always_comb
    begin
        pos_next      = pos_reg;
        header_next   = header_reg;
        x_next        = x_reg;
        prev_btn_next = prev_btn_reg;
        res_valid     = 1'b0;
        res_data.delta_x     = x_reg;
        res_data.delta_y     = 9'd0 - y_ext;
        res_data.button_mask = buttons;

        if (cfg_write && paddr == REG_ENABLE)
        begin
            // rewriting 1 while already enabled keeps the packet position
            if (!pwdata[0] || !enable_reg)
            begin
                pos_next = POS_HEADER;
                if (pwdata[0])
                    prev_btn_next = '0;
            end
        end
        else if (consume)
        begin
            if (!enable_reg)
                pos_next = POS_HEADER;
            else
            begin
                unique case (pos_reg)
                    POS_HEADER:
                    begin
                        if ((s_tdata & HDR_SYNC_BIT) != 8'h00)
                        begin
                            header_next = s_tdata;
                            pos_next    = POS_X;
                        end
                    end
                    POS_X:
                    begin
                        x_next   = s_tdata;
                        pos_next = POS_Y;
                    end
                    POS_Y:
                    begin
                        pos_next = POS_HEADER;
                        if ((header_reg & HDR_OVERFLOW) == 8'h00 &&
                            (x_reg != 8'h00 || s_tdata != 8'h00 || buttons != prev_btn_reg))
                        begin
                            res_valid     = 1'b1;
                            prev_btn_next = buttons;
                        end
                    end
                    default:
                    begin
                        pos_next = POS_HEADER;
                    end
                endcase
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            pos_reg      <= POS_HEADER;
            prev_btn_reg <= '0;
        end
        else
        begin
            if (cfg_write && paddr == REG_ENABLE)
                enable_reg <= pwdata[0];
            pos_reg      <= pos_next;
            prev_btn_reg <= prev_btn_next;
        end
    end

    // Stored packet bytes
    always_ff @(posedge clk)
    begin
        header_reg <= header_next;
        x_reg      <= x_next;
    end

    // Output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_xfer)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xfer)
                out_data_reg <= skid_data_reg;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_xfer)
                out_data_reg <= res_data;
            else
                skid_data_reg <= res_data;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

endmodule
